@@ hdl/rrq_pkg.sv @@
package rrq_pkg;

    typedef enum logic [1:0] {
        OP_ADMIT  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    localparam int THREAD_ID_W = 8;
    localparam int COUNT_W     = 5;

endpackage

@@ hdl/round_robin_run_queue_top.sv @@
// Channel  | Signals                                          | Transfer
// ---------+--------------------------------------------------+---------------------------
// command  | start, opcode, thread_id / busy                  | edge with start && !busy
// result   | done, status, head_id, head_valid, entry_count   | edge ending the done cycle
//
// Admit, query and a remove on an empty queue finish at once: done rises the cycle after the transfer.
// Remove walks the slot memory one entry per cycle through its single registered
// read port: it compares slots in order until it finds the id, then moves each later
// entry down one slot to close the gap, and done follows.
// Reset empties the queue; slot contents are not cleared. done cannot be stalled.
module round_robin_run_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [rrq_pkg::THREAD_ID_W-1:0]    thread_id,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [rrq_pkg::THREAD_ID_W-1:0]    head_id,
    output logic                               head_valid,
    output logic [rrq_pkg::COUNT_W-1:0]        entry_count
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TW     = rrq_pkg::THREAD_ID_W;
    localparam int CW     = rrq_pkg::COUNT_W;

    rrq_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [ID_BITS-1:0] head_reg, head_next;
    logic               done_reg, done_next;
    rrq_pkg::status_t   status_reg, status_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;

    logic [ID_BITS+TW-1:0] id_wide;
    logic [ID_BITS-1:0]    id_in;
    logic [CNT_W-1:0]      idx_plus1;
    logic [ID_BITS+TW-1:0] head_wide;
    logic [CNT_W+CW-1:0]   occ_wide;

    assign id_wide   = {{ID_BITS{1'b0}}, thread_id};
    assign id_in     = id_wide[ID_BITS-1:0];
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);

    rrq_slot_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (ID_BITS),
        .ADDR_W (ADDR_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        id_next     = id_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = occ_reg[ADDR_W-1:0];
        mem_wdata   = id_in;
        mem_raddr   = '0;

        unique case (state_reg)
            rrq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    id_next = id_in;
                    unique case (rrq_pkg::opcode_t'(opcode))
                        rrq_pkg::OP_ADMIT:
                        begin
                            done_next = 1'b1;
                            if (occ_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = rrq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                occ_next    = occ_reg + CNT_W'(1);
                                status_next = rrq_pkg::ST_OK;
                                if (occ_reg == '0)
                                begin
                                    head_next = id_in;
                                end
                            end
                        end
                        rrq_pkg::OP_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = rrq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // fetch slot 0 for the first compare
                                idx_next   = '0;
                                state_next = rrq_pkg::S_CMP;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = (occ_reg == '0) ? rrq_pkg::ST_EMPTY
                                                          : rrq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            rrq_pkg::S_CMP:
            begin
                // compare slot idx while fetching slot idx + 1
                mem_raddr = idx_plus1[ADDR_W-1:0];
                if (mem_rdata == id_reg)
                begin
                    occ_next = occ_reg - CNT_W'(1);
                    if (CNT_W'(idx_reg) < occ_reg - CNT_W'(1))
                    begin
                        state_next = rrq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = rrq_pkg::ST_OK;
                        state_next  = rrq_pkg::S_IDLE;
                    end
                end
                else if (idx_plus1 < occ_reg)
                begin
                    idx_next = idx_plus1[ADDR_W-1:0];
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = rrq_pkg::ST_NOT_FOUND;
                    state_next  = rrq_pkg::S_IDLE;
                end
            end
            rrq_pkg::S_SHIFT:
            begin
                // move slot idx + 1 down into slot idx, fetch the one after
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_reg + ADDR_W'(2);
                if (idx_reg == '0)
                begin
                    head_next = mem_rdata;
                end
                idx_next = idx_plus1[ADDR_W-1:0];
                if (idx_plus1 >= occ_reg)
                begin
                    done_next   = 1'b1;
                    status_next = rrq_pkg::ST_OK;
                    state_next  = rrq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrq_pkg::S_IDLE;
            end
        endcase

        if (state_reg == rrq_pkg::S_IDLE && start)
        begin
            mem_raddr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrq_pkg::S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        id_reg     <= id_next;
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    assign head_wide = {{TW{1'b0}}, head_reg};
    assign occ_wide  = {{CW{1'b0}}, occ_reg};

    assign busy        = (state_reg != rrq_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign head_valid  = (occ_reg != '0);
    assign head_id     = head_valid ? head_wide[TW-1:0] : '0;
    assign entry_count = occ_wide[CW-1:0];

endmodule

@@ hdl/rrq_slot_mem.sv @@
module rrq_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 2 * QUEUE_DEPTH + 8;
    localparam int TW          = rrq_pkg::THREAD_ID_W;
    localparam int CW          = rrq_pkg::COUNT_W;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]    op;
        logic [TW-1:0] id;
        int            gap;
        bit            drain;
    } run_cmd_t;

    typedef struct {
        rrq_pkg::status_t st;
        logic [TW-1:0]    head;
        logic             valid;
        logic [CW-1:0]    cnt;
    } queue_view_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [1:0]    opcode = rrq_pkg::OP_QUERY;
    logic [TW-1:0] thread_id = '0;
    logic          busy;
    logic          done;
    logic [1:0]    status;
    logic [TW-1:0] head_id;
    logic          head_valid;
    logic [CW-1:0] entry_count;

    run_cmd_t      cmd_backlog[$];
    queue_view_t   expected_views[$];
    logic [TW-1:0] model_slots[QUEUE_DEPTH];
    int            model_count = 0;
    int            errors = 0;
    int            stall_cycles = 0;
    bit            taken = 0;
    bit            have_next = 0;
    run_cmd_t      next_cmd;
    int            gap_left = 0;

    round_robin_run_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .thread_id  (thread_id),
        .done       (done),
        .status     (status),
        .head_id    (head_id),
        .head_valid (head_valid),
        .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    // Apply one operation to the shadow queue and return the view it produces.
    function automatic queue_view_t run_queue_step(logic [1:0] op,
                                                   logic [TW-1:0] id);
        queue_view_t v;
        int          hit;
        int          i;
        hit = -1;
        case (op)
            rrq_pkg::OP_ADMIT:
                if (model_count >= QUEUE_DEPTH)
                    v.st = rrq_pkg::ST_FULL;
                else
                begin
                    model_slots[model_count] = id;
                    model_count++;
                    v.st = rrq_pkg::ST_OK;
                end
            rrq_pkg::OP_REMOVE:
                if (model_count == 0)
                    v.st = rrq_pkg::ST_EMPTY;
                else
                begin
                    for (i = 0; i < model_count; i++)
                        if (hit < 0 && model_slots[i] == id)
                            hit = i;
                    if (hit < 0)
                        v.st = rrq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        // close the gap, keeping order
                        for (i = hit; i + 1 < model_count; i++)
                            model_slots[i] = model_slots[i + 1];
                        model_count--;
                        v.st = rrq_pkg::ST_OK;
                    end
                end
            default:
                v.st = (model_count == 0) ? rrq_pkg::ST_EMPTY : rrq_pkg::ST_OK;
        endcase
        v.head  = (model_count > 0) ? model_slots[0] : '0;
        v.valid = (model_count > 0);
        v.cnt   = CW'(model_count);
        return v;
    endfunction

    // Monitor: check results first, then record the command transfer of this edge.
    always @(posedge clk)
    begin
        queue_view_t want;
        if (rst_n)
        begin
            stall_cycles = stall_cycles + 1;
            if (done)
            begin
                stall_cycles = 0;
                if (expected_views.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result st=%0d head=%0d valid=%0d cnt=%0d",
                                 $realtime, status, head_id, head_valid, entry_count);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (status !== want.st || head_id !== want.head ||
                        head_valid !== want.valid || entry_count !== want.cnt)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp st=%0d head=%0d valid=%0d cnt=%0d,",
                                      " got st=%0d head=%0d valid=%0d cnt=%0d"},
                                     $realtime, want.st, want.head, want.valid, want.cnt,
                                     status, head_id, head_valid, entry_count);
                    end
                end
            end
            if (start && !busy)
            begin
                stall_cycles = 0;
                taken = 1;
                expected_views.push_back(run_queue_step(opcode, thread_id));
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Driver: present commands at the falling edge, hold until transferred.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !taken))
        begin
            taken = 0;
            if (!have_next && cmd_backlog.size() > 0)
            begin
                next_cmd  = cmd_backlog.pop_front();
                have_next = 1;
                gap_left  = next_cmd.gap;
            end
            if (have_next && gap_left == 0 &&
                !(next_cmd.drain && expected_views.size() != 0))
            begin
                opcode    <= next_cmd.op;
                thread_id <= next_cmd.id;
                start     <= 1'b1;
                have_next = 0;
            end
            else
            begin
                start     <= 1'b0;
                opcode    <= 2'($urandom);
                thread_id <= TW'($urandom);
                if (have_next && gap_left > 0)
                    gap_left--;
            end
        end
    end

    initial
    begin
        logic [TW-1:0] shadow[$];
        run_cmd_t      c;
        int            r;
        int            k;
        int            admit_pct;
        bit            lazy;

        // directed: empty queue, id extremes, duplicates, absent id, full queue
        c.gap = 0;
        c.drain = 0;
        c.op = rrq_pkg::OP_QUERY;  c.id = 8'h00; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'h00; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_ADMIT;  c.id = 8'hFF; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_ADMIT;  c.id = 8'h00; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_ADMIT;  c.id = 8'h00; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'h00; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'hAA; cmd_backlog.push_back(c);
        c.op = OP_SPARE;           c.id = 8'h55; cmd_backlog.push_back(c);
        shadow = '{8'hFF, 8'h00};
        for (k = 0; k < QUEUE_DEPTH - 2; k++)
        begin
            c.op = rrq_pkg::OP_ADMIT;
            c.id = TW'(8'h10 + k);
            cmd_backlog.push_back(c);
            shadow.push_back(c.id);
        end
        c.op = rrq_pkg::OP_ADMIT;  c.id = 8'h77; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'h1D; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'h15; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_REMOVE; c.id = 8'hFF; cmd_backlog.push_back(c);
        c.op = rrq_pkg::OP_QUERY;  c.id = 8'h00; cmd_backlog.push_back(c);
        shadow.delete(shadow.size() - 1);
        shadow.delete(7);
        shadow.delete(0);

        // random: each phase picks its fill bias and whether to idle at random
        lazy = 0;
        admit_pct = 45;
        for (k = 0; k < 900; k++)
        begin
            if (k % 60 == 0)
            begin
                lazy = 1'($urandom_range(0, 1));
                admit_pct = ($urandom_range(0, 2) == 0) ? 75 : 45;
            end
            c.gap   = lazy ? $urandom_range(0, 12) : 0;
            c.drain = (k % 150 == 149);
            r = $urandom_range(0, 99);
            if (r < admit_pct)
            begin
                c.op = rrq_pkg::OP_ADMIT;
                c.id = TW'($urandom);
                if (shadow.size() < QUEUE_DEPTH)
                    shadow.push_back(c.id);
            end
            else if (r < 85 && shadow.size() > 0)
            begin
                c.op = rrq_pkg::OP_REMOVE;
                c.id = shadow[$urandom_range(0, shadow.size() - 1)];
                foreach (shadow[i])
                    if (shadow[i] == c.id)
                    begin
                        shadow.delete(i);
                        break;
                    end
            end
            else if (r < 92)
            begin
                c.op = rrq_pkg::OP_REMOVE;
                c.id = TW'($urandom);
                foreach (shadow[i])
                    if (shadow[i] == c.id)
                    begin
                        shadow.delete(i);
                        break;
                    end
            end
            else
            begin
                c.op = (r < 97) ? rrq_pkg::OP_QUERY : OP_SPARE;
                c.id = TW'($urandom);
            end
            cmd_backlog.push_back(c);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || have_next || (start && !taken))
            @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && expected_views.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
